// File: hw/rtl/iiea_pkg.sv
// Shared types, codes and sizes for the indexed insert/erase array.
package iiea_pkg;

    // Default number of entries
    localparam int CAPACITY_DEF = 16;

    // Fixed field widths
    localparam int WORD_W  = 64;
    localparam int INDEX_W = 5;
    localparam int LEN_W   = 5;

    // Operation codes
    localparam logic [2:0] MODE_SET    = 3'd0;
    localparam logic [2:0] MODE_GET    = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_ERASE  = 3'd3;
    localparam logic [2:0] MODE_PUSH   = 3'd4;
    localparam logic [2:0] MODE_POP    = 3'd5;
    localparam logic [2:0] MODE_CLEAR  = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Cell update codes
    localparam logic [1:0] CELL_HOLD     = 2'd0;
    localparam logic [1:0] CELL_LOAD     = 2'd1;
    localparam logic [1:0] CELL_SHIFT_UP = 2'd2;  // take the lower neighbor
    localparam logic [1:0] CELL_SHIFT_DN = 2'd3;  // take the upper neighbor

    typedef struct packed {
        logic [2:0]        mode;
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [LEN_W-1:0]  length;
        logic              is_empty;
        logic [1:0]        status;
    } t_rsp;

    // Per-cell control
    typedef struct packed {
        logic [1:0] op;
        logic       rd;
    } t_cell_ctl;

endpackage

// File: hw/rtl/iiea_cell.sv
// One storage cell of the array: holds a word, loads, or shifts from a neighbor.
module iiea_cell (
    input  logic                            i_clk,
    input  iiea_pkg::t_cell_ctl             i_ctl,
    input  logic [iiea_pkg::WORD_W-1:0]     i_value,
    input  logic [iiea_pkg::WORD_W-1:0]     i_lo,
    input  logic [iiea_pkg::WORD_W-1:0]     i_hi,
    output logic [iiea_pkg::WORD_W-1:0]     o_data,
    output logic [iiea_pkg::WORD_W-1:0]     o_rd
);

    logic [iiea_pkg::WORD_W-1:0] r_data;
    logic [iiea_pkg::WORD_W-1:0] n_data;

    // Pick the next word
    always_comb begin
        unique case (i_ctl.op)
            iiea_pkg::CELL_LOAD:     n_data = i_value;
            iiea_pkg::CELL_SHIFT_UP: n_data = i_lo;
            iiea_pkg::CELL_SHIFT_DN: n_data = i_hi;
            default:                 n_data = r_data;
        endcase
    end

    // Hold the word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Drive the word onto the read bus only when selected
    assign o_rd   = r_data & {iiea_pkg::WORD_W{i_ctl.rd}};

endmodule

// File: hw/rtl/indexed_insert_erase_array.sv
// Top level of the indexed insert/erase array: control, cell chain and response.
//
// Usage:
//   Raise start with a request on i_req (mode, index, value). The request is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only while reset is held, so one request can be taken every cycle.
//   Each request yields one response on o_rsp, marked by o_valid for exactly
//   one cycle, in the cycle right after the request is taken.
//   The receiver cannot stall the response; it must take it in that cycle.
//   Throughput is one request per cycle: every cell of the chain loads,
//   holds or takes its neighbor's word in parallel, so insert and erase
//   finish in the same cycle as set or get.
//   The response carries the word read by a get, the length after the
//   operation (low five bits), an empty flag and a status code. A request
//   that fails leaves the array untouched.
//   Reset (i_rst_n low, synchronous) empties the array and drops any
//   pending response; old words are never visible after reset.
module indexed_insert_erase_array #(
    parameter int CAPACITY = iiea_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  iiea_pkg::t_req i_req,
    output logic           o_valid,
    output iiea_pkg::t_rsp o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > iiea_pkg::INDEX_W) ? CW : iiea_pkg::INDEX_W;

    logic                    accept;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_valid;
    iiea_pkg::t_rsp          r_rsp;
    iiea_pkg::t_rsp          n_rsp;
    logic [XW-1:0]           idx_x;
    logic [XW-1:0]           cnt_x;
    logic                    empty_now;
    logic                    full_now;
    logic                    set_ok;
    logic                    get_ok;
    logic                    ins_ok;
    logic                    ers_ok;
    logic                    push_ok;
    logic [1:0]              status;
    logic [iiea_pkg::WORD_W-1:0] rd_word;

    logic [iiea_pkg::WORD_W-1:0] cell_data [CAPACITY];
    logic [iiea_pkg::WORD_W-1:0] cell_rd [CAPACITY];

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    assign idx_x     = XW'(i_req.index);
    assign cnt_x     = XW'(r_count);
    assign empty_now = (r_count == '0);
    assign full_now  = (r_count == CW'(CAPACITY));

    // Decode the request into status, next length and operation enables
    always_comb begin
        status  = iiea_pkg::ST_OK;
        n_count = r_count;
        set_ok  = 1'b0;
        get_ok  = 1'b0;
        ins_ok  = 1'b0;
        ers_ok  = 1'b0;
        push_ok = 1'b0;
        unique case (i_req.mode) inside
            iiea_pkg::MODE_SET, iiea_pkg::MODE_GET, iiea_pkg::MODE_ERASE: begin
                if (empty_now) begin
                    status = iiea_pkg::ST_EMPTY;
                end else if (idx_x >= cnt_x) begin
                    status = iiea_pkg::ST_INDEX;
                end else if (i_req.mode == iiea_pkg::MODE_SET) begin
                    set_ok = 1'b1;
                end else if (i_req.mode == iiea_pkg::MODE_GET) begin
                    get_ok = 1'b1;
                end else begin
                    ers_ok  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            iiea_pkg::MODE_INSERT: begin
                if (idx_x > cnt_x) begin
                    status = iiea_pkg::ST_INDEX;
                end else if (full_now) begin
                    status = iiea_pkg::ST_FULL;
                end else begin
                    ins_ok  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            iiea_pkg::MODE_PUSH: begin
                if (full_now) begin
                    status = iiea_pkg::ST_FULL;
                end else begin
                    push_ok = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            iiea_pkg::MODE_POP: begin
                if (empty_now) begin
                    status = iiea_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            iiea_pkg::MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Build the cell chain with per-cell control
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam logic [XW-1:0] POS = XW'(k);
        logic [iiea_pkg::WORD_W-1:0] lo_word;
        logic [iiea_pkg::WORD_W-1:0] hi_word;
        iiea_pkg::t_cell_ctl         ctl;

        if (k == 0) begin : g_first
            assign lo_word = '0;
        end else begin : g_mid_lo
            assign lo_word = cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign hi_word = '0;
        end else begin : g_mid_hi
            assign hi_word = cell_data[k+1];
        end

        always_comb begin
            ctl.op = iiea_pkg::CELL_HOLD;
            ctl.rd = get_ok && (idx_x == POS);
            if (accept) begin
                if ((set_ok || ins_ok) && (idx_x == POS)) begin
                    ctl.op = iiea_pkg::CELL_LOAD;
                end else if (ins_ok && (POS > idx_x) && (POS <= cnt_x)) begin
                    ctl.op = iiea_pkg::CELL_SHIFT_UP;
                end else if (push_ok && (POS == cnt_x)) begin
                    ctl.op = iiea_pkg::CELL_LOAD;
                end else if (ers_ok && (POS >= idx_x)) begin
                    ctl.op = iiea_pkg::CELL_SHIFT_DN;
                end
            end
        end

        iiea_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_value (i_req.value),
            .i_lo    (lo_word),
            .i_hi    (hi_word),
            .o_data  (cell_data[k]),
            .o_rd    (cell_rd[k])
        );
    end

    // Merge the selected cell onto the read bus
    always_comb begin
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_word = rd_word | cell_rd[k];
        end
    end

    // Assemble the response
    always_comb begin
        n_rsp.read_value = rd_word;
        n_rsp.length     = iiea_pkg::LEN_W'(n_count);
        n_rsp.is_empty   = (n_count == '0);
        n_rsp.status     = status;
    end

    // Advance length and response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Response strobe is raised in the cycle after every taken request
    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(start && !busy))
        else $error("response strobe does not match taken request");

    // Length never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Empty flag agrees with the stored length
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.is_empty == (r_count == '0)))
        else $error("empty flag disagrees with length");

    // Failed request leaves the length alone
    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != iiea_pkg::ST_OK)) |-> (r_count == $past(r_count)))
        else $error("failed request changed the length");

    // Only a get returns a nonzero word
    a_read_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.read_value != '0)) |-> ($past(i_req.mode) == iiea_pkg::MODE_GET))
        else $error("nonzero read word on a non-get request");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the indexed insert/erase array.
module tb_top;

    localparam int CLK_HIGH = 6;
    localparam int CLK_LOW = 6;
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam logic [iiea_pkg::WORD_W-1:0] ALL_ONES = '1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int ITEM_GOAL = 1250;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    iiea_pkg::t_req i_req = '0;
    logic o_valid;
    iiea_pkg::t_rsp o_rsp;

    // predicted array contents and length
    logic [iiea_pkg::WORD_W-1:0] model_words [iiea_pkg::CAPACITY_DEF];
    int unsigned model_count = 0;

    iiea_pkg::t_rsp pending_rsp [$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned items_sent = 0;

    indexed_insert_erase_array #(
        .CAPACITY(iiea_pkg::CAPACITY_DEF)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW i_clk = 1'b0;
    end

    // Apply one request to the predicted array and return its response
    function automatic iiea_pkg::t_rsp apply_array_op(input iiea_pkg::t_req req);
        iiea_pkg::t_rsp rsp;
        int unsigned pos;
        int unsigned k;
        rsp = '0;
        rsp.status = iiea_pkg::ST_OK;
        pos = 32'(req.index);
        case (req.mode) inside
            iiea_pkg::MODE_SET, iiea_pkg::MODE_GET, iiea_pkg::MODE_ERASE: begin
                if (model_count == 0) begin
                    rsp.status = iiea_pkg::ST_EMPTY;
                end else if (pos >= model_count) begin
                    rsp.status = iiea_pkg::ST_INDEX;
                end else if (req.mode == iiea_pkg::MODE_SET) begin
                    model_words[pos] = req.value;
                end else if (req.mode == iiea_pkg::MODE_GET) begin
                    rsp.read_value = model_words[pos];
                end else begin
                    for (k = pos; k + 1 < model_count; k++)
                        model_words[k] = model_words[k + 1];
                    model_count--;
                end
            end
            iiea_pkg::MODE_INSERT: begin
                if (pos > model_count) begin
                    rsp.status = iiea_pkg::ST_INDEX;
                end else if (model_count >= iiea_pkg::CAPACITY_DEF) begin
                    rsp.status = iiea_pkg::ST_FULL;
                end else begin
                    for (k = model_count; k > pos; k--)
                        model_words[k] = model_words[k - 1];
                    model_words[pos] = req.value;
                    model_count++;
                end
            end
            iiea_pkg::MODE_PUSH: begin
                if (model_count >= iiea_pkg::CAPACITY_DEF) begin
                    rsp.status = iiea_pkg::ST_FULL;
                end else begin
                    model_words[model_count] = req.value;
                    model_count++;
                end
            end
            iiea_pkg::MODE_POP: begin
                if (model_count == 0)
                    rsp.status = iiea_pkg::ST_EMPTY;
                else
                    model_count--;
            end
            iiea_pkg::MODE_CLEAR: begin
                model_count = 0;
            end
            default: begin
            end
        endcase
        rsp.length = iiea_pkg::LEN_W'(model_count);
        rsp.is_empty = (model_count == 0);
        return rsp;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [iiea_pkg::WORD_W-1:0] got,
                                   input logic [iiea_pkg::WORD_W-1:0] want);
        mismatch_count++;
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Check each response against the oldest prediction, then queue the new one
    always @(posedge i_clk) begin : check_rsp
        iiea_pkg::t_rsp want;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("response with no request pending",
                                    o_rsp.read_value, '0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.read_value !== want.read_value)
                        report_mismatch("read_value", o_rsp.read_value, want.read_value);
                    if (o_rsp.length !== want.length)
                        report_mismatch("length", 64'(o_rsp.length), 64'(want.length));
                    if (o_rsp.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 64'(o_rsp.is_empty),
                                        64'(want.is_empty));
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", 64'(o_rsp.status), 64'(want.status));
                end
            end
            if (start && busy === 1'b0)
                pending_rsp.push_back(apply_array_op(i_req));
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("indexed_insert_erase_array test failed");
            $finish;
        end
    end

    // Driving tasks start and end just after a falling edge
    task automatic send_op(input logic [2:0] op_mode, input int unsigned pos,
                           input logic [iiea_pkg::WORD_W-1:0] value);
        start <= 1'b1;
        i_req <= '{mode: op_mode, index: iiea_pkg::INDEX_W'(pos), value: value};
        items_sent++;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            start <= 1'b0;
            i_req <= '{mode: 3'($urandom), index: iiea_pkg::INDEX_W'($urandom),
                       value: {$urandom, $urandom}};
            @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    // Mostly back to back, often short gaps, now and then a long one
    task automatic random_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll >= 93)
            idle_cycles($urandom_range(8, 40));
        else if (roll >= 55)
            idle_cycles($urandom_range(1, 3));
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending_rsp.size() != 0)
            idle_cycles(1);
    endtask

    function automatic logic [iiea_pkg::WORD_W-1:0] rand_word();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 16)
            return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    // Send one random request; grow_pct is the percent of resizing requests that grow
    task automatic send_random_op(input int unsigned grow_pct);
        int unsigned roll;
        int unsigned pos;
        logic [2:0] op_mode;
        roll = $urandom_range(99);
        if (roll < 1)
            op_mode = iiea_pkg::MODE_CLEAR;
        else if (roll < 2)
            op_mode = MODE_UNUSED;
        else if (roll < 40)
            op_mode = $urandom_range(1) ? iiea_pkg::MODE_GET : iiea_pkg::MODE_SET;
        else if ($urandom_range(99) < grow_pct)
            op_mode = $urandom_range(1) ? iiea_pkg::MODE_INSERT : iiea_pkg::MODE_PUSH;
        else
            op_mode = $urandom_range(1) ? iiea_pkg::MODE_ERASE : iiea_pkg::MODE_POP;
        // mostly legal positions, sometimes any five-bit index
        if ($urandom_range(99) < 15)
            pos = $urandom_range(31);
        else if (op_mode == iiea_pkg::MODE_INSERT)
            pos = $urandom_range(model_count);
        else if (model_count == 0)
            pos = 0;
        else
            pos = $urandom_range(model_count - 1);
        send_op(op_mode, pos, rand_word());
    endtask

    // Empty array, index limits, every operation and the unused code
    task automatic test_edges();
        send_op(iiea_pkg::MODE_SET, 0, ALL_ONES);
        send_op(iiea_pkg::MODE_GET, 0, '0);
        send_op(iiea_pkg::MODE_ERASE, 0, '0);
        send_op(iiea_pkg::MODE_POP, 0, '0);
        send_op(iiea_pkg::MODE_INSERT, 1, ALL_ONES);
        send_op(iiea_pkg::MODE_INSERT, 31, ALL_ONES);
        send_op(iiea_pkg::MODE_INSERT, 0, ALL_ONES);
        send_op(iiea_pkg::MODE_INSERT, 1, '0);
        send_op(iiea_pkg::MODE_INSERT, 0, 64'hA5A5_5A5A_0F0F_F0F0);
        send_op(iiea_pkg::MODE_GET, 3, '0);
        send_op(iiea_pkg::MODE_GET, 31, ALL_ONES);
        send_op(iiea_pkg::MODE_SET, 3, ALL_ONES);
        send_op(iiea_pkg::MODE_ERASE, 3, '0);
        send_op(iiea_pkg::MODE_GET, 0, '0);
        send_op(iiea_pkg::MODE_GET, 1, '0);
        send_op(iiea_pkg::MODE_GET, 2, '0);
        send_op(iiea_pkg::MODE_SET, 2, 64'h0123_4567_89AB_CDEF);
        send_op(iiea_pkg::MODE_ERASE, 0, '0);
        send_op(iiea_pkg::MODE_PUSH, 0, ALL_ONES);
        send_op(iiea_pkg::MODE_POP, 0, '0);
        send_op(MODE_UNUSED, 31, ALL_ONES);
        send_op(iiea_pkg::MODE_GET, 1, '0);
        send_op(iiea_pkg::MODE_CLEAR, 0, '0);
        send_op(iiea_pkg::MODE_GET, 0, '0);
        send_op(iiea_pkg::MODE_PUSH, 31, ALL_ONES);
    endtask

    // Fill to capacity, probe the full cases, then drain from random positions
    task automatic test_full_array();
        while (model_count < iiea_pkg::CAPACITY_DEF) begin
            send_op(iiea_pkg::MODE_INSERT, $urandom_range(model_count), rand_word());
            random_gap();
        end
        send_op(iiea_pkg::MODE_INSERT, iiea_pkg::CAPACITY_DEF, rand_word());
        send_op(iiea_pkg::MODE_INSERT, iiea_pkg::CAPACITY_DEF + 1, rand_word());
        send_op(iiea_pkg::MODE_PUSH, 0, rand_word());
        send_op(iiea_pkg::MODE_GET, iiea_pkg::CAPACITY_DEF - 1, '0);
        send_op(iiea_pkg::MODE_SET, iiea_pkg::CAPACITY_DEF - 1, ALL_ONES);
        send_op(iiea_pkg::MODE_ERASE, iiea_pkg::CAPACITY_DEF - 1, '0);
        send_op(iiea_pkg::MODE_PUSH, 0, rand_word());
        send_op(iiea_pkg::MODE_GET, iiea_pkg::CAPACITY_DEF, '0);
        while (model_count > 0) begin
            send_op(iiea_pkg::MODE_ERASE, $urandom_range(model_count - 1), '0);
            random_gap();
        end
    endtask

    // Bursts of requests, each followed by a pause until every response is in
    task automatic test_pause_until_drained();
        repeat (3) begin
            repeat (12)
                send_random_op(60);
            wait_drained();
            idle_cycles($urandom_range(2, 12));
        end
    endtask

    // Episodes that drift toward full or toward empty
    task automatic test_random_walk();
        int unsigned ep_len;
        int unsigned grow_pct;
        logic gaps_on;
        while (items_sent < ITEM_GOAL) begin
            ep_len = $urandom_range(20, 60);
            grow_pct = $urandom_range(1) ? 75 : 25;
            gaps_on = ($urandom_range(3) != 0);
            repeat (ep_len) begin
                send_random_op(grow_pct);
                if (gaps_on)
                    random_gap();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < iiea_pkg::CAPACITY_DEF; i++)
            model_words[i] = '0;
        // hold reset, then release it just after a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edges();
        test_full_array();
        test_pause_until_drained();
        test_random_walk();

        wait_drained();
        idle_cycles(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("indexed_insert_erase_array test passed");
        else
            $display("indexed_insert_erase_array test failed");
        $finish;
    end

endmodule
